FILE: hdl/fnmf_pkg.sv
// Shared types and constants of the four-neighbor mean filter.
`timescale 1ns / 1ps

package fnmf_pkg;

  // Fixed widths of the configuration port and of the result fields.
  localparam int DIM_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int MEAN_W      = 16;
  localparam int CNT_W       = 3;
  localparam int POS_W       = 10;
  localparam int MAX_RESULTS = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_idx_e;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [MEAN_W-1:0] mean_q8;
    logic [CNT_W-1:0]  neighbor_count;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_column;
    logic              frame_end;
  } res_t;

endpackage

FILE: hdl/fnmf_if.sv
// Stream interfaces for the pixel input and the result output.
`timescale 1ns / 1ps

interface fnmf_pixel_if #(
  parameter int PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface fnmf_result_if
  import fnmf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_q8;
  logic [CNT_W-1:0]  neighbor_count;
  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_column;
  logic              frame_end;

  modport source (output valid, output mean_q8, output neighbor_count, output out_row,
                  output out_column, output frame_end, input ready);
  modport sink (input valid, input mean_q8, input neighbor_count, input out_row,
                input out_column, input frame_end, output ready);
endinterface

FILE: hdl/fnmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fnmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/fnmf_mean.sv
// Neighbor sum to Q8.8 mean: divide by 2, 3 or 4 (by 1 for any other count), truncate and saturate.
`timescale 1ns / 1ps

module fnmf_mean
  import fnmf_pkg::*;
#(
  parameter int SUM_W = 10
) (
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output logic [MEAN_W-1:0] mean_q8_o
);

  localparam int MW    = SUM_W + 8;
  localparam int EXT_W = (MW > MEAN_W + 1) ? MW : MEAN_W + 1;
  // Even shift so that 2^K = 1 mod 3; exact for sums below 2^(K-1).
  localparam int K     = SUM_W + 1 + ((SUM_W + 1) % 2);
  localparam logic [K-1:0] RECIP3 = K'(((2 ** K) + 2) / 3);

  logic [SUM_W+K-1:0] prod3;
  logic [SUM_W-1:0]   third;
  logic [MW-1:0]      mean_wide;
  logic [EXT_W-1:0]   mean_ext;

  // sum*256/3 = 85*sum + floor(sum/3)
  assign prod3 = (SUM_W + K)'(sum_i) * (SUM_W + K)'(RECIP3);
  assign third = SUM_W'(prod3 >> K);

  always_comb begin
    case (cnt_i)
      CNT_W'(2): mean_wide = MW'(sum_i) << 7;
      CNT_W'(3): mean_wide = MW'(sum_i) * MW'(85) + MW'(third);
      CNT_W'(4): mean_wide = MW'(sum_i) << 6;
      default:   mean_wide = MW'(sum_i) << 8;
    endcase
  end

  assign mean_ext  = EXT_W'(mean_wide);
  assign mean_q8_o = (mean_ext > EXT_W'(17'h0FFFF)) ? {MEAN_W{1'b1}} : MEAN_W'(mean_ext);

endmodule

FILE: hdl/four_neighbor_mean_filter.sv
// Top level of the four-neighbor mean filter over a raster pixel stream.
`timescale 1ns / 1ps

//  Channel   Dir  Handshake        Payload
//  pix_i     in   valid / ready    pixel (PIXEL_BITS, unsigned, raster order)
//  res_o     out  valid / ready    mean_q8, neighbor_count, out_row, out_column, frame_end
//  cfg_*     in   write enable     cfg_idx_i selects image_columns or image_rows
//
//  A pixel is taken every cycle. Its results are held in the job register and
//  leave through the output register one per cycle, so a pixel with one result
//  keeps the full rate, and a last-row pixel with two or three results holds ready
//  low while the output register drains the job. A stalled output holds the job
//  and then the input. Reset clears control state only; the two line stores start
//  undefined and need no clearing pass.

module four_neighbor_mean_filter
  import fnmf_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fnmf_pixel_if.sink           pix_i,
  fnmf_result_if.source        res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  // Column and row counters index the raster; the *_DW widths also hold the
  // image dimensions themselves.
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int COL_DW = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_DW = $clog2(MAX_ROWS + 1);
  localparam int SUM_W = PIXEL_BITS + 2;
  localparam logic [COL_DW-1:0] COLS_RST = COL_DW'((MAX_COLUMNS < 3) ? MAX_COLUMNS : 3);
  localparam logic [ROW_DW-1:0] ROWS_RST = ROW_DW'((MAX_ROWS < 3) ? MAX_ROWS : 3);

  // One pending result: the neighbor sum and where it belongs.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             fend;
  } slot_t;

  // Dimensions are stored already clamped to the legal range.
  function automatic logic [COL_DW-1:0] clamp_cols(logic [DIM_W-1:0] v);
    logic [COL_DW-1:0] r;
    if (v < DIM_W'(2)) begin
      r = COL_DW'(2);
    end else if (int'(v) > MAX_COLUMNS) begin
      r = COL_DW'(MAX_COLUMNS);
    end else begin
      r = COL_DW'(v);
    end
    return r;
  endfunction

  function automatic logic [ROW_DW-1:0] clamp_rows(logic [DIM_W-1:0] v);
    logic [ROW_DW-1:0] r;
    if (v < DIM_W'(2)) begin
      r = ROW_DW'(2);
    end else if (int'(v) > MAX_ROWS) begin
      r = ROW_DW'(MAX_ROWS);
    end else begin
      r = ROW_DW'(v);
    end
    return r;
  endfunction

  // Configuration and raster position.
  logic [COL_DW-1:0] cols_q;
  logic [ROW_DW-1:0] rows_q;
  logic [CW-1:0]     col_q;
  logic [RW-1:0]     row_q;

  // Pixel history. above_q is the newer-line sample of the current column,
  // fetched one transfer ahead; prev_q is the one of the column before.
  logic [PIXEL_BITS-1:0] above_q;
  logic [PIXEL_BITS-1:0] prev_q;
  logic [PIXEL_BITS-1:0] sec_prev_q;
  logic [PIXEL_BITS-1:0] last_pix_q;
  logic                  fwd_q;
  logic [PIXEL_BITS-1:0] fwd_pix_q;

  // Job register and output register.
  slot_t       job_q [MAX_RESULTS];
  slot_t       job_d [MAX_RESULTS];
  logic [1:0]  job_n_q;
  logic [1:0]  job_n_d;
  logic        out_valid_q;
  res_t        out_res_q;
  logic [MEAN_W-1:0] mean_q8;

  logic in_ready;
  logic accept;
  logic emit;

  logic [PIXEL_BITS-1:0] pix;
  logic [PIXEL_BITS-1:0] older_rd;
  logic [PIXEL_BITS-1:0] newer_rd;
  logic [PIXEL_BITS-1:0] right_pix;
  logic [PIXEL_BITS-1:0] prev_in;

  logic              c_ge1;
  logic              c_ge2;
  logic              r_ge2;
  logic              c_last;
  logic              last_row;
  logic [COL_DW-1:0] col_inc;
  logic [COL_DW-1:0] col_next_inc;
  logic [CW-1:0]     col_next;
  logic [CW-1:0]     ahead_addr;
  logic [RW-1:0]     row_next;
  logic [RW-1:0]     row_m1;
  logic [CW-1:0]     col_m1;
  logic [1:0]        new_n;
  slot_t             new_slot [MAX_RESULTS];

  assign pix = pix_i.pixel;

  // A new pixel is taken once the job register is empty or gives up its last
  // result in this cycle.
  assign emit     = (job_n_q != 2'd0) && (!out_valid_q || res_o.ready);
  assign in_ready = (job_n_q == 2'd0) || ((job_n_q == 2'd1) && emit);
  assign accept   = pix_i.valid && in_ready;
  assign pix_i.ready = in_ready;

  // Raster bookkeeping.
  assign c_ge1    = (col_q != '0);
  assign c_ge2    = (COL_DW'(col_q) >= COL_DW'(2));
  assign r_ge2    = (ROW_DW'(row_q) >= ROW_DW'(2));
  assign col_inc  = COL_DW'(col_q) + COL_DW'(1);
  assign c_last   = (col_inc == cols_q);
  assign last_row = ((ROW_DW'(row_q) + ROW_DW'(1)) == rows_q);
  assign col_next = c_last ? '0 : CW'(col_inc);
  assign row_next = c_last ? (last_row ? '0 : row_q + RW'(1)) : row_q;
  assign row_m1   = row_q - RW'(1);
  assign col_m1   = col_q - CW'(1);

  // The newer line is read one column beyond the next pixel, so that its data
  // serves as the right neighbor now and as the pixel above one transfer later.
  assign col_next_inc = COL_DW'(col_next) + COL_DW'(1);
  assign ahead_addr   = (col_next_inc == cols_q) ? '0 : CW'(col_next_inc);

  // With two columns the look-ahead read hits the column being written; the
  // incoming pixel is forwarded in that case.
  assign right_pix = fwd_q ? fwd_pix_q : newer_rd;
  assign prev_in   = c_ge1 ? last_pix_q : '0;

  fnmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_older_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (above_q),
    .re_i    (accept),
    .raddr_i (col_next),
    .rdata_o (older_rd)
  );

  fnmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_COLUMNS)
  ) u_newer_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (pix),
    .re_i    (accept),
    .raddr_i (ahead_addr),
    .rdata_o (newer_rd)
  );

  // Results released by this pixel, in delivery order: the pixel one row up,
  // then in the last row the left neighbor, then at the very end the pixel itself.
  always_comb begin
    new_slot[0].sum = SUM_W'(pix)
                    + (r_ge2 ? SUM_W'(older_rd) : '0)
                    + (c_ge1 ? SUM_W'(prev_q) : '0)
                    + (!c_last ? SUM_W'(right_pix) : '0);
    new_slot[0].cnt = CNT_W'(1) + CNT_W'(r_ge2) + CNT_W'(c_ge1) + CNT_W'(!c_last);
    new_slot[0].row = POS_W'(row_m1);
    new_slot[0].col = POS_W'(col_q);
    new_slot[0].fend = 1'b0;

    // In the last row, the older line at the left column holds prev_q.
    new_slot[1].sum = SUM_W'(prev_q) + SUM_W'(pix) + (c_ge2 ? SUM_W'(sec_prev_q) : '0);
    new_slot[1].cnt = CNT_W'(2) + CNT_W'(c_ge2);
    new_slot[1].row = POS_W'(row_q);
    new_slot[1].col = POS_W'(col_m1);
    new_slot[1].fend = 1'b0;

    new_slot[2].sum = SUM_W'(above_q) + SUM_W'(prev_in);
    new_slot[2].cnt = CNT_W'(2);
    new_slot[2].row = POS_W'(row_q);
    new_slot[2].col = POS_W'(col_q);
    new_slot[2].fend = 1'b1;

    if (row_q == '0) begin
      new_n = 2'd0;
    end else if (!(last_row && c_ge1)) begin
      new_n = 2'd1;
    end else if (!c_last) begin
      new_n = 2'd2;
    end else begin
      new_n = 2'd3;
    end
  end

  // Job register: loaded on a transfer in, shifted down on each result sent.
  always_comb begin
    job_d   = job_q;
    job_n_d = job_n_q;
    if (accept) begin
      job_d   = new_slot;
      job_n_d = new_n;
    end else if (emit) begin
      job_d[0] = job_q[1];
      job_d[1] = job_q[2];
      job_n_d  = job_n_q - 2'd1;
    end
  end

  fnmf_mean #(
    .SUM_W (SUM_W)
  ) u_mean (
    .sum_i     (job_q[0].sum),
    .cnt_i     (job_q[0].cnt),
    .mean_q8_o (mean_q8)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= COLS_RST;
      rows_q      <= ROWS_RST;
      col_q       <= '0;
      row_q       <= '0;
      prev_q      <= '0;
      sec_prev_q  <= '0;
      fwd_q       <= 1'b0;
      job_n_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // Any register write restarts the frame; the line stores keep their data.
        unique case (cfg_idx_i)
          CFG_COLUMNS: cols_q <= clamp_cols(cfg_data_i);
          CFG_ROWS:    rows_q <= clamp_rows(cfg_data_i);
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_next;
        row_q <= row_next;
      end
      if (accept) begin
        prev_q     <= above_q;
        sec_prev_q <= prev_in;
        fwd_q      <= (ahead_addr == col_q);
      end
      job_n_q <= job_n_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q    <= right_pix;
      last_pix_q <= pix;
      fwd_pix_q  <= pix;
    end
    job_q <= job_d;
    if (emit) begin
      out_res_q.mean_q8        <= mean_q8;
      out_res_q.neighbor_count <= job_q[0].cnt;
      out_res_q.out_row        <= job_q[0].row;
      out_res_q.out_column     <= job_q[0].col;
      out_res_q.frame_end      <= job_q[0].fend;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.mean_q8        = out_res_q.mean_q8;
  assign res_o.neighbor_count = out_res_q.neighbor_count;
  assign res_o.out_row        = out_res_q.out_row;
  assign res_o.out_column     = out_res_q.out_column;
  assign res_o.frame_end      = out_res_q.frame_end;

endmodule
